@@ rtl/lkvc_pkg.sv @@
package lkvc_pkg;

    localparam int DATA_W              = 32;
    localparam int CAP_W               = 5;
    localparam int PADDR_W             = 3;
    localparam int PDATA_W             = 32;
    localparam int DEFAULT_MAX_ENTRIES = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;
    localparam logic              REG_CAPACITY = 1'b0;

    localparam logic              CMD_GET = 1'b0;
    localparam logic              CMD_PUT = 1'b1;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

endpackage

@@ rtl/lru_key_value_cache_core.sv @@
// Fully associative key/value cache with least-recently-used replacement.
//
// Input channel (in_valid/in_ready): one request per transaction; cmd selects
// get or put, key is looked up in every slot at once, value is stored by a put.
// Output channel (out_valid/out_ready): exactly one result per request, in
// order: found, read_value (-1 unless a get hits) and evicted.
// Configuration: APB-style port, capacity at byte address 0 (low 5 bits of
// pwdata). Zero behaves as 1, values above MAX_ENTRIES behave as MAX_ENTRIES.
// Write it only while no request is in flight.
//
// Pipeline: an accepted request is held in the input register, and is processed
// from there into the result register, which offers it on the output channel.
// Throughput: one request per cycle while the receiver takes results, set by
// the combinational key compare and rank update across all slots.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only when both are occupied.
// Reset clears all valid bits, recency ranks and the entry count, empties both
// pipeline registers and sets capacity to 16. Keys and values are not cleared.
module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = lkvc_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkvc_pkg::PADDR_W-1:0]  paddr,
    input  logic [lkvc_pkg::PDATA_W-1:0]  pwdata,
    output logic [lkvc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic signed [lkvc_pkg::DATA_W-1:0] key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] value,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value,
    output logic                          evicted
);

    localparam int DATA_W = lkvc_pkg::DATA_W;
    localparam int CAP_W  = lkvc_pkg::CAP_W;
    localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // configuration
    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_write;

    // input register
    logic              s1_valid_reg;
    logic              s1_cmd_reg;
    logic [DATA_W-1:0] s1_key_reg;
    logic [DATA_W-1:0] s1_value_reg;

    // result register
    logic              out_valid_reg;
    logic              found_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic              evicted_reg;

    // slot state
    logic [DATA_W-1:0] slot_key_reg   [MAX_ENTRIES];
    logic [DATA_W-1:0] slot_value_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] slot_valid_reg;
    logic [MAX_ENTRIES-1:0] slot_valid_next;
    logic [RANK_W-1:0] slot_rank_reg  [MAX_ENTRIES];
    logic [RANK_W-1:0] slot_rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]  used_count_reg;
    logic [CNT_W-1:0]  used_count_next;

    // lookup
    logic              advance;
    logic [CMP_W-1:0]  cap_eff;
    logic [RANK_W-1:0] last_rank;
    logic [MAX_ENTRIES-1:0] hit_vec;
    logic [MAX_ENTRIES-1:0] hit_first_vec;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic [MAX_ENTRIES-1:0] oldest_vec;
    logic [MAX_ENTRIES-1:0] touch_vec;
    logic [MAX_ENTRIES-1:0] write_vec;
    logic              hit_any;
    logic              free_any;
    logic              do_fill;
    logic              do_evict;
    logic              do_touch;
    logic [RANK_W-1:0] touch_rank;
    logic [DATA_W-1:0] hit_value;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == lkvc_pkg::REG_CAPACITY);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == lkvc_pkg::REG_CAPACITY)
        begin
            prdata = {{(lkvc_pkg::PDATA_W-CAP_W){1'b0}}, capacity_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_write)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // pipeline handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign read_value = read_value_reg;
    assign evicted   = evicted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg   <= cmd;
            s1_key_reg   <= key;
            s1_value_reg <= value;
        end
        if (advance)
        begin
            found_reg      <= hit_any;
            read_value_reg <= (hit_any && (s1_cmd_reg == lkvc_pkg::CMD_GET)) ?
                              hit_value : lkvc_pkg::MISS_VALUE;
            evicted_reg    <= do_evict;
        end
    end

    // effective capacity: clamp to 1..MAX_ENTRIES
    always_comb
    begin
        cap_eff = CMP_W'(capacity_reg);
        if (capacity_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(MAX_ENTRIES))
        begin
            cap_eff = CMP_W'(MAX_ENTRIES);
        end
    end

    // ranks of valid slots form 0..used_count-1, so the oldest holds the top rank
    assign last_rank = RANK_W'(used_count_reg - CNT_W'(1));

    always_comb
    begin
        logic hit_seen;
        logic free_seen;
        hit_seen      = 1'b0;
        free_seen     = 1'b0;
        hit_first_vec = '0;
        free_vec      = '0;
        touch_rank    = '0;
        hit_value     = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_vec[i]    = slot_valid_reg[i] && (slot_key_reg[i] == s1_key_reg);
            oldest_vec[i] = slot_valid_reg[i] && (slot_rank_reg[i] == last_rank);
            if (hit_vec[i] && !hit_seen)
            begin
                hit_first_vec[i] = 1'b1;
                hit_seen         = 1'b1;
            end
            if (!slot_valid_reg[i] && !free_seen)
            begin
                free_vec[i] = 1'b1;
                free_seen   = 1'b1;
            end
        end
        hit_any  = hit_seen;
        free_any = free_seen;

        do_fill  = (s1_cmd_reg == lkvc_pkg::CMD_PUT) && !hit_any && free_any &&
                   (CMP_W'(used_count_reg) < cap_eff);
        do_evict = (s1_cmd_reg == lkvc_pkg::CMD_PUT) && !hit_any && !do_fill &&
                   (|oldest_vec);
        do_touch = hit_any || do_evict;

        touch_vec = hit_any ? hit_first_vec : oldest_vec;
        if (do_fill)
        begin
            write_vec = free_vec;
        end
        else if (s1_cmd_reg == lkvc_pkg::CMD_PUT)
        begin
            write_vec = touch_vec;
        end
        else
        begin
            write_vec = '0;
        end

        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (touch_vec[i])
            begin
                touch_rank = touch_rank | slot_rank_reg[i];
            end
            if (hit_first_vec[i])
            begin
                hit_value = hit_value | slot_value_reg[i];
            end
        end
    end

    // recency update
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        used_count_next = used_count_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            slot_rank_next[i] = slot_rank_reg[i];
            if (do_touch)
            begin
                if (touch_vec[i])
                begin
                    slot_rank_next[i] = '0;
                end
                else if (slot_valid_reg[i] && (slot_rank_reg[i] < touch_rank))
                begin
                    slot_rank_next[i] = slot_rank_reg[i] + RANK_W'(1);
                end
            end
            else if (do_fill)
            begin
                if (free_vec[i])
                begin
                    slot_rank_next[i]  = '0;
                    slot_valid_next[i] = 1'b1;
                end
                else if (slot_valid_reg[i])
                begin
                    slot_rank_next[i] = slot_rank_reg[i] + RANK_W'(1);
                end
            end
        end
        if (do_fill)
        begin
            used_count_next = used_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            used_count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                slot_rank_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            slot_valid_reg <= slot_valid_next;
            used_count_reg <= used_count_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                slot_rank_reg[i] <= slot_rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (write_vec[i])
                begin
                    slot_key_reg[i]   <= s1_key_reg;
                    slot_value_reg[i] <= s1_value_reg;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == int'(used_count_reg))
        else $error("entry count disagrees with valid bits");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot0(hit_vec))
        else $error("key present in more than one slot");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(found_reg && evicted_reg))
        else $error("eviction reported for a hit");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (read_value_reg == lkvc_pkg::MISS_VALUE))
        else $error("miss returned a stored value");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int SLOTS       = lkvc_pkg::DEFAULT_MAX_ENTRIES;
    localparam int POOL_SIZE   = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;

    typedef struct packed {
        logic                        found;
        logic [lkvc_pkg::DATA_W-1:0] read_value;
        logic                        evicted;
    } cache_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lkvc_pkg::PADDR_W-1:0]  paddr;
    logic [lkvc_pkg::PDATA_W-1:0]  pwdata;
    logic [lkvc_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic                          cmd;
    logic [lkvc_pkg::DATA_W-1:0]   key;
    logic [lkvc_pkg::DATA_W-1:0]   value;
    logic                          out_valid;
    logic                          out_ready;
    logic                          found;
    logic [lkvc_pkg::DATA_W-1:0]   read_value;
    logic                          evicted;

    // Shadow copy of the cache contents
    logic [lkvc_pkg::CAP_W-1:0]    cfg_capacity = lkvc_pkg::CAP_RESET;
    logic [lkvc_pkg::DATA_W-1:0]   slot_key_q   [SLOTS];
    logic [lkvc_pkg::DATA_W-1:0]   slot_value_q [SLOTS];
    logic                          slot_valid_q [SLOTS];
    int                            slot_rank_q  [SLOTS];
    int                            entries_used;

    cache_result_t                 pending_results[$];
    logic [lkvc_pkg::DATA_W-1:0]   key_pool[POOL_SIZE];
    int                            error_count = 0;
    int                            idle_cycles = 0;
    int                            stall_left  = 0;
    int                            hold_left   = 0;
    logic                          hold_start  = 1'b0;
    logic                          idle_on     = 1'b1;

    lru_key_value_cache_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .read_value (read_value),
        .evicted    (evicted)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Make slot s most recent; newer valid entries age by one
    function automatic void promote_slot(int s);
        int r;
        begin
            r = slot_rank_q[s];
            for (int i = 0; i < SLOTS; i++)
                if (i != s && slot_valid_q[i] && slot_rank_q[i] < r)
                    slot_rank_q[i]++;
            slot_rank_q[s] = 0;
        end
    endfunction

    function automatic cache_result_t cache_lookup(logic c,
                                                   logic [lkvc_pkg::DATA_W-1:0] k,
                                                   logic [lkvc_pkg::DATA_W-1:0] v);
        cache_result_t res;
        int            lim;
        int            hit;
        int            free_slot;
        int            oldest;
        begin
            res.found      = 1'b0;
            res.read_value = lkvc_pkg::MISS_VALUE;
            res.evicted    = 1'b0;
            lim = cfg_capacity;
            if (lim < 1)
                lim = 1;
            if (lim > SLOTS)
                lim = SLOTS;
            hit = -1;
            free_slot = -1;
            oldest = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_valid_q[i])
                begin
                    if (hit < 0 && slot_key_q[i] == k)
                        hit = i;
                    if (oldest < 0 || slot_rank_q[i] > slot_rank_q[oldest])
                        oldest = i;
                end
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (hit >= 0)
            begin
                res.found = 1'b1;
                if (c == lkvc_pkg::CMD_GET)
                    res.read_value = slot_value_q[hit];
                else
                    slot_value_q[hit] = v;
                promote_slot(hit);
            end
            else if (c == lkvc_pkg::CMD_PUT)
            begin
                if (entries_used < lim && free_slot >= 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid_q[i])
                            slot_rank_q[i]++;
                    slot_valid_q[free_slot] = 1'b1;
                    slot_key_q[free_slot]   = k;
                    slot_value_q[free_slot] = v;
                    slot_rank_q[free_slot]  = 0;
                    entries_used++;
                end
                else if (oldest >= 0)
                begin
                    slot_key_q[oldest]   = k;
                    slot_value_q[oldest] = v;
                    promote_slot(oldest);
                    res.evicted = 1'b1;
                end
            end
            return res;
        end
    endfunction

    function automatic logic [lkvc_pkg::DATA_W-1:0] pick_key(int pool_n);
        begin
            if ($urandom_range(0, 9) < 8)
                return key_pool[$urandom_range(0, pool_n - 1)];
            return $urandom;
        end
    endfunction

    task automatic send_request(input logic c, input logic [lkvc_pkg::DATA_W-1:0] k,
                                input logic [lkvc_pkg::DATA_W-1:0] v);
        int gap;
        begin
            gap = 0;
            if (idle_on && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 7);
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            cmd      <= c;
            key      <= k;
            value    <= v;
            do
                @(posedge clk);
            while (!in_ready);
            pending_results.push_back(cache_lookup(c, k, v));
        end
    endtask

    // Drop valid, drain every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
        logic [lkvc_pkg::PDATA_W-1:0] data;
        begin
            wait_idle();
            data = $urandom;
            data[lkvc_pkg::CAP_W-1:0] = cap;
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= lkvc_pkg::PADDR_W'(lkvc_pkg::REG_CAPACITY * 4);
            pwdata  <= data;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            cfg_capacity = data[lkvc_pkg::CAP_W-1:0];
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
    endtask

    task automatic run_requests(input int count, input int pool_n);
        logic c;
        begin
            for (int n = 0; n < count; n++)
            begin
                c = 1'($urandom_range(0, 1));
                send_request(c, pick_key(pool_n), $urandom);
            end
        end
    endtask

    task automatic test_directed_corners();
        begin
            // zero capacity behaves as a single entry
            write_capacity(5'd0);
            send_request(lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
            send_request(lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
            send_request(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000);
            send_request(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
            send_request(lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
            send_request(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h1234_5678);
            send_request(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
            write_capacity(5'd3);
            send_request(lkvc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
            send_request(lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
            send_request(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
            send_request(lkvc_pkg::CMD_PUT, 32'h0000_0001, 32'hA5A5_A5A5);
            send_request(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
            send_request(lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
            send_request(lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000);
            send_request(lkvc_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000);
        end
    endtask

    // Capacity below the entry count: every put of a new key evicts
    task automatic test_lowered_capacity();
        begin
            write_capacity(5'd1);
            run_requests(150, 5);
        end
    endtask

    task automatic test_capacity_growth();
        begin
            write_capacity(5'd7);
            run_requests(250, 12);
        end
    endtask

    task automatic test_capacity_over_range();
        begin
            write_capacity(5'd31);
            run_requests(350, 28);
        end
    endtask

    task automatic test_back_pressure();
        begin
            write_capacity(5'd5);
            @(posedge clk);
            hold_start = 1'b1;
            run_requests(60, 8);
            // sender pauses here until every result is back
            wait_idle();
        end
    endtask

    task automatic test_capacity_max();
        begin
            write_capacity(5'd16);
            run_requests(350, 24);
        end
    endtask

    task automatic test_capacity_mid();
        begin
            write_capacity(5'd9);
            run_requests(300, 12);
        end
    endtask

    task automatic test_no_idling();
        begin
            write_capacity(5'd16);
            idle_on = 1'b0;
            run_requests(450, 20);
        end
    endtask

    // Receiver: long hold-off on request, otherwise random stall bursts while idle_on is set
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 7) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result found=%0b read_value=%h evicted=%0b",
                         $time, found, read_value, evicted);
                error_count++;
            end
            else
            begin
                cache_result_t exp_res;
                exp_res = pending_results.pop_front();
                if (found !== exp_res.found || read_value !== exp_res.read_value
                    || evicted !== exp_res.evicted)
                begin
                    $display("%0t: mismatch expected found=%0b read_value=%h evicted=%0b",
                             $time, exp_res.found, exp_res.read_value, exp_res.evicted,
                             ", actual found=%0b read_value=%h evicted=%0b",
                             found, read_value, evicted);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[lru_key_value_cache_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        cmd      = lkvc_pkg::CMD_GET;
        key      = '0;
        value    = '0;
        out_ready = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_key_q[i]   = '0;
            slot_value_q[i] = '0;
            slot_valid_q[i] = 1'b0;
            slot_rank_q[i]  = 0;
        end
        entries_used = 0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_lowered_capacity();
        test_capacity_growth();
        test_capacity_over_range();
        test_back_pressure();
        test_capacity_max();
        test_capacity_mid();
        test_no_idling();

        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[lru_key_value_cache_core] OK");
        else
            $display("[lru_key_value_cache_core] ERROR");
        $finish;
    end

endmodule
